@@ rtl/tfn_pkg.sv @@
// ----------------------------------------------------------------------------
// Triangle face normal package
// Shared widths, operation codes, phase codes and control types.
// ----------------------------------------------------------------------------
package tfn_pkg;

	localparam int DEF_MAX_VERTICES = 1024;
	localparam int IDX_W            = 10;
	localparam int COORD_W          = 16;
	localparam int STEP_W           = 6;
	localparam int PHASE_W          = 4;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_FACE  = 1'b1;

	localparam logic [PHASE_W-1:0] P_IDLE = 4'd0;
	localparam logic [PHASE_W-1:0] P_READ = 4'd1;
	localparam logic [PHASE_W-1:0] P_MUL  = 4'd2;
	localparam logic [PHASE_W-1:0] P_ABS  = 4'd3;
	localparam logic [PHASE_W-1:0] P_NORM = 4'd4;
	localparam logic [PHASE_W-1:0] P_SQ   = 4'd5;
	localparam logic [PHASE_W-1:0] P_ROOT = 4'd6;
	localparam logic [PHASE_W-1:0] P_DIV  = 4'd7;
	localparam logic [PHASE_W-1:0] P_DONE = 4'd8;

	localparam logic [STEP_W-1:0] READ_LAST = 6'd3;
	localparam logic [STEP_W-1:0] MUL_LAST  = 6'd6;
	localparam logic [STEP_W-1:0] SQ_LAST   = 6'd3;
	localparam logic [STEP_W-1:0] ROOT_LAST = 6'd32;
	localparam logic [STEP_W-1:0] DIV_LAST  = 6'd47;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [STEP_W-1:0]  step;
		logic               load;
		logic               wr;
		logic               out_load;
	} cmd_t;

	typedef struct packed {
		logic zero;
		logic norm_done;
	} sts_t;

endpackage

@@ rtl/tfn_ctrl.sv @@
// ----------------------------------------------------------------------------
// Triangle face normal controller
// Sequences vertex reads, cross product, scaling, square root and division.
// ----------------------------------------------------------------------------
module tfn_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          operation,
	output logic          out_valid,
	input  logic          out_stall,
	input  tfn_pkg::sts_t sts,
	output tfn_pkg::cmd_t cmd
);

	logic [tfn_pkg::PHASE_W-1:0] state_q, state_d;
	logic [tfn_pkg::STEP_W-1:0]  step_q;
	logic                        out_valid_q;
	logic                        accept;
	logic                        out_free;

	assign in_stall  = (state_q != tfn_pkg::P_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tfn_pkg::P_IDLE: if (accept && operation == tfn_pkg::OP_FACE) state_d = tfn_pkg::P_READ;
			tfn_pkg::P_READ: if (step_q == tfn_pkg::READ_LAST) state_d = tfn_pkg::P_MUL;
			tfn_pkg::P_MUL:  if (step_q == tfn_pkg::MUL_LAST) state_d = tfn_pkg::P_ABS;
			tfn_pkg::P_ABS:  state_d = tfn_pkg::P_NORM;
			tfn_pkg::P_NORM: begin
				if (sts.zero) state_d = tfn_pkg::P_DONE;
				else if (sts.norm_done) state_d = tfn_pkg::P_SQ;
			end
			tfn_pkg::P_SQ:   if (step_q == tfn_pkg::SQ_LAST) state_d = tfn_pkg::P_ROOT;
			tfn_pkg::P_ROOT: if (step_q == tfn_pkg::ROOT_LAST) state_d = tfn_pkg::P_DIV;
			tfn_pkg::P_DIV:  if (step_q == tfn_pkg::DIV_LAST) state_d = tfn_pkg::P_DONE;
			tfn_pkg::P_DONE: if (out_free) state_d = tfn_pkg::P_IDLE;
			default:         state_d = tfn_pkg::P_IDLE;
		endcase
	end

	always_comb begin
		cmd.phase    = state_q;
		cmd.step     = step_q;
		cmd.load     = accept && (operation == tfn_pkg::OP_FACE);
		cmd.wr       = accept && (operation == tfn_pkg::OP_WRITE);
		cmd.out_load = (state_q == tfn_pkg::P_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tfn_pkg::P_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) step_q <= '0;
			else step_q <= step_q + 1'b1;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_load_in_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> state_q == tfn_pkg::P_DONE)
		else $error("result loaded outside the done phase");
	a_root_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tfn_pkg::P_ROOT && step_q == tfn_pkg::ROOT_LAST) |=>
		state_q == tfn_pkg::P_DIV)
		else $error("square root did not hand over to division");
	a_zero_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tfn_pkg::P_NORM && sts.zero) |=> state_q == tfn_pkg::P_DONE)
		else $error("zero normal did not finish at once");
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == tfn_pkg::P_DONE)
		else $error("result word appeared without a finished face");
`endif

endmodule

@@ rtl/tfn_dpath.sv @@
// ----------------------------------------------------------------------------
// Triangle face normal datapath
// Vertex store, shared multiplier, scaling, bitwise square root and divider.
// ----------------------------------------------------------------------------
module tfn_dpath #(
	parameter int MAX_VERTICES = tfn_pkg::DEF_MAX_VERTICES
) (
	input  logic                              clk,
	input  tfn_pkg::cmd_t                     cmd,
	output tfn_pkg::sts_t                     sts,
	input  logic [tfn_pkg::IDX_W-1:0]         vertex_index,
	input  logic signed [tfn_pkg::COORD_W-1:0] coord_x,
	input  logic signed [tfn_pkg::COORD_W-1:0] coord_y,
	input  logic signed [tfn_pkg::COORD_W-1:0] coord_z,
	input  logic [tfn_pkg::IDX_W-1:0]         corner_a,
	input  logic [tfn_pkg::IDX_W-1:0]         corner_b,
	input  logic [tfn_pkg::IDX_W-1:0]         corner_c,
	input  logic                              last_face,
	output logic signed [15:0]                normal_x,
	output logic signed [15:0]                normal_y,
	output logic signed [15:0]                normal_z,
	output logic                              degenerate,
	output logic                              last_normal
);

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam logic [16:0] MAXV = 17'(MAX_VERTICES);

	logic [47:0] mem [MAX_VERTICES];
	logic [47:0] rdata_q;
	logic        rd_ok_q;

	logic [tfn_pkg::IDX_W-1:0] corner_q [3];
	logic                      last_q;
	logic [47:0]               p_q [3];
	logic signed [16:0]        u [3];
	logic signed [16:0]        v [3];
	logic signed [16:0]        opa, opb;
	logic signed [33:0]        prod_q;
	logic signed [34:0]        c_q [3];
	logic [33:0]               mag_q [3];
	logic [33:0]               mx;
	logic                      deg_q;
	logic [61:0]               sq_q;
	logic [63:0]               sum_q;
	logic [63:0]               rem_q, root_q, bit_q;
	logic [63:0]               trial_root;
	logic [31:0]               len;
	logic [1:0]                comp;
	logic [3:0]                sub;
	logic [45:0]               num;
	logic [31:0]               drem_q;
	logic [14:0]               dlow_q;
	logic [14:0]               dq_q, qn;
	logic [32:0]               trial;
	logic                      ge;
	logic [15:0]               qclamp;
	logic signed [15:0]        n_q [3];
	logic [16:0]               widx, ridx;
	logic [tfn_pkg::IDX_W-1:0] rsel;
	logic [2:0]                mstep;
	logic [2:0]                pidx;

	assign widx = 17'(vertex_index);
	assign rsel = corner_q[cmd.step[1:0] == 2'd0 ? 0 : (cmd.step[1:0] == 2'd1 ? 1 : 2)];
	assign ridx = 17'(rsel);

	always_ff @(posedge clk) begin
		if (cmd.wr && widx < MAXV) mem[widx[AW-1:0]] <= {coord_x, coord_y, coord_z};
		rdata_q <= mem[ridx[AW-1:0]];
		rd_ok_q <= ridx < MAXV;
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			u[k] = 17'(signed'(p_q[1][47-16*k -: 16])) - 17'(signed'(p_q[0][47-16*k -: 16]));
			v[k] = 17'(signed'(p_q[2][47-16*k -: 16])) - 17'(signed'(p_q[0][47-16*k -: 16]));
		end
		mstep = cmd.step[2:0];
		unique case (mstep)
			3'd0:    begin opa = u[1]; opb = v[2]; end
			3'd1:    begin opa = u[2]; opb = v[1]; end
			3'd2:    begin opa = u[2]; opb = v[0]; end
			3'd3:    begin opa = u[0]; opb = v[2]; end
			3'd4:    begin opa = u[0]; opb = v[1]; end
			default: begin opa = u[1]; opb = v[0]; end
		endcase
		pidx = mstep - 3'd1;
	end

	always_comb begin
		mx = mag_q[0];
		if (mag_q[1] > mx) mx = mag_q[1];
		if (mag_q[2] > mx) mx = mag_q[2];
		sts.zero      = (mx == '0);
		sts.norm_done = (mx[33:31] == 3'd0) && mx[30];
	end

	always_comb begin
		trial_root = root_q + bit_q;
		len        = root_q[31:0];
		comp       = cmd.step[5:4];
		sub        = cmd.step[3:0];
		num        = {mag_q[comp][30:0], 14'd0} + 46'(len >> 1);
		trial      = {drem_q, dlow_q[14]};
		ge         = trial >= {1'b0, len};
		qn         = {dq_q[13:0], ge};
		qclamp     = ({1'b0, qn} > 16'd16384) ? 16'd16384 : {1'b0, qn};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			corner_q[0] <= corner_a;
			corner_q[1] <= corner_b;
			corner_q[2] <= corner_c;
			last_q      <= last_face;
			deg_q       <= 1'b0;
		end
		unique case (cmd.phase)
			tfn_pkg::P_READ: begin
				if (cmd.step != '0) p_q[cmd.step[1:0] - 2'd1] <= rd_ok_q ? rdata_q : '0;
			end
			tfn_pkg::P_MUL: begin
				if (mstep != 3'd6) prod_q <= opa * opb;
				if (mstep != 3'd0) begin
					if (!pidx[0]) c_q[pidx[2:1]] <= 35'(prod_q);
					else c_q[pidx[2:1]] <= c_q[pidx[2:1]] - 35'(prod_q);
				end
			end
			tfn_pkg::P_ABS: begin
				for (int k = 0; k < 3; k++)
					mag_q[k] <= c_q[k][34] ? 34'(-c_q[k]) : c_q[k][33:0];
			end
			tfn_pkg::P_NORM: begin
				deg_q <= sts.zero;
				if (!sts.zero && !sts.norm_done) begin
					for (int k = 0; k < 3; k++) begin
						if (mx[33:31] != 3'd0) mag_q[k] <= mag_q[k] >> 1;
						else if (mx[33:26] == 8'd0) mag_q[k] <= mag_q[k] << 4;
						else mag_q[k] <= mag_q[k] << 1;
					end
				end
			end
			tfn_pkg::P_SQ: begin
				if (cmd.step[1:0] != 2'd3)
					sq_q <= mag_q[cmd.step[1:0]][30:0] * mag_q[cmd.step[1:0]][30:0];
				if (cmd.step == '0) sum_q <= '0;
				else sum_q <= sum_q + 64'(sq_q);
			end
			tfn_pkg::P_ROOT: begin
				if (cmd.step == '0) begin
					rem_q  <= sum_q;
					root_q <= '0;
					bit_q  <= 64'd1 << 62;
				end else begin
					if (rem_q >= trial_root) begin
						rem_q  <= rem_q - trial_root;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			tfn_pkg::P_DIV: begin
				if (sub == 4'd0) begin
					drem_q <= {1'b0, num[45:15]};
					dlow_q <= num[14:0];
					dq_q   <= '0;
				end else begin
					drem_q <= ge ? 32'(trial - {1'b0, len}) : trial[31:0];
					dlow_q <= dlow_q << 1;
					dq_q   <= qn;
					if (sub == 4'd15) n_q[comp] <= c_q[comp][34] ? -signed'(qclamp) : signed'(qclamp);
				end
			end
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			normal_x    <= deg_q ? '0 : n_q[0];
			normal_y    <= deg_q ? '0 : n_q[1];
			normal_z    <= deg_q ? '0 : n_q[2];
			degenerate  <= deg_q;
			last_normal <= last_q;
		end
	end

endmodule

@@ rtl/triangle_face_normal_core.sv @@
// ----------------------------------------------------------------------------
// Triangle face normal core
// Unit face normals in Q1.14 over a store of Q8.8 vertices.
// ----------------------------------------------------------------------------
// A vertex word is written to the store and gives no result. A face word is
// worked in order: store reads, the one shared multiplier for the cross
// product, the magnitudes, scaling, the squared length, the bitwise square
// root, the three 15-bit divisions and the load of the result. A face with a
// zero cross product skips the squared length, the root and the divisions.
// The input stalls while a face is in work and is free again on the cycle
// after the load, so a new face is not taken before the last one is loaded.
// The result sits in an output register, so a new word is taken while it
// waits. A face finishes only once that register is free.
module triangle_face_normal_core #(
	parameter int MAX_VERTICES = tfn_pkg::DEF_MAX_VERTICES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               operation,
	input  logic [tfn_pkg::IDX_W-1:0]          vertex_index,
	input  logic signed [tfn_pkg::COORD_W-1:0] coord_x,
	input  logic signed [tfn_pkg::COORD_W-1:0] coord_y,
	input  logic signed [tfn_pkg::COORD_W-1:0] coord_z,
	input  logic [tfn_pkg::IDX_W-1:0]          corner_a,
	input  logic [tfn_pkg::IDX_W-1:0]          corner_b,
	input  logic [tfn_pkg::IDX_W-1:0]          corner_c,
	input  logic                               last_face,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [15:0]                 normal_x,
	output logic signed [15:0]                 normal_y,
	output logic signed [15:0]                 normal_z,
	output logic                               degenerate,
	output logic                               last_normal
);

	tfn_pkg::cmd_t cmd;
	tfn_pkg::sts_t sts;

	tfn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tfn_dpath #(.MAX_VERTICES(MAX_VERTICES)) u_dpath (
		.clk          (clk),
		.cmd          (cmd),
		.sts          (sts),
		.vertex_index (vertex_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.coord_z      (coord_z),
		.corner_a     (corner_a),
		.corner_b     (corner_b),
		.corner_c     (corner_c),
		.last_face    (last_face),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z),
		.degenerate   (degenerate),
		.last_normal  (last_normal)
	);

endmodule

@@ tb/triangle_face_normal_core_tb.sv @@
// ----------------------------------------------------------------------------
// Triangle face normal core testbench
// Writes Q8.8 vertices into the store and sends faces over written corners.
// Each normal is checked against a local integer face normal predictor, or against the table for typed words.
// ----------------------------------------------------------------------------
// A short table of directed words comes first, then random words. Both ports
// idle at random, except for one long stretch where they do not.
module triangle_face_normal_core_tb;

	typedef struct {
		logic                      op;
		logic [tfn_pkg::IDX_W-1:0] idx;
		logic signed [15:0]        x, y, z;
		logic [tfn_pkg::IDX_W-1:0] a, b, c;
		logic                      last;
		bit                        typed;
		logic signed [15:0]        nx, ny, nz;
		logic                      deg;
	} row_t;

	typedef struct {
		logic signed [15:0] nx, ny, nz;
		logic              deg, last;
	} normal_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = tfn_pkg::OP_WRITE;
	logic [tfn_pkg::IDX_W-1:0] vertex_index = '0;
	logic signed [tfn_pkg::COORD_W-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
	logic [tfn_pkg::IDX_W-1:0] corner_a = '0, corner_b = '0, corner_c = '0;
	logic last_face = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic degenerate, last_normal;

	logic signed [15:0] vstore [tfn_pkg::DEF_MAX_VERTICES][3];
	bit written [tfn_pkg::DEF_MAX_VERTICES];
	logic [tfn_pkg::IDX_W-1:0] written_list [$];
	normal_t pending_normals [$];
	int errors = 0;
	int cycle_count = 0;
	int n_writes = 0, n_faces = 0, n_checked = 0, n_degenerate = 0;

	triangle_face_normal_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit quiet_now();
		return cycle_count >= 30000 && cycle_count < 60000;
	endfunction

	function automatic normal_t face_normal(logic [tfn_pkg::IDX_W-1:0] a, b, c, logic last);
		longint u [3], v [3], cr [3];
		bit [63:0] mag [3], mx, sum, rem, root, bt, len, q;
		normal_t r;
		for (int k = 0; k < 3; k++) begin
			u[k] = longint'(vstore[b][k]) - longint'(vstore[a][k]);
			v[k] = longint'(vstore[c][k]) - longint'(vstore[a][k]);
		end
		cr[0] = u[1] * v[2] - u[2] * v[1];
		cr[1] = u[2] * v[0] - u[0] * v[2];
		cr[2] = u[0] * v[1] - u[1] * v[0];
		r.last = last;
		r.deg = 1'b0;
		mx = 0;
		for (int k = 0; k < 3; k++) begin
			mag[k] = (cr[k] < 0) ? -cr[k] : cr[k];
			if (mag[k] > mx)
				mx = mag[k];
		end
		if (mx == 0) begin
			r.nx = 0;
			r.ny = 0;
			r.nz = 0;
			r.deg = 1'b1;
			return r;
		end
		while (mx >= 64'd1 << 31) begin
			mx >>= 1;
			for (int k = 0; k < 3; k++)
				mag[k] >>= 1;
		end
		while (mx < 64'd1 << 30) begin
			mx <<= 1;
			for (int k = 0; k < 3; k++)
				mag[k] <<= 1;
		end
		sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
		rem = sum;
		root = 0;
		bt = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= root + bt) begin
				rem -= root + bt;
				root = (root >> 1) + bt;
			end else begin
				root >>= 1;
			end
			bt >>= 2;
		end
		len = (root == 0) ? 1 : root;
		for (int k = 0; k < 3; k++) begin
			q = ((mag[k] << 14) + (len >> 1)) / len;
			if (q > 16384)
				q = 16384;
			if (cr[k] < 0)
				q = -q;
			case (k)
				0: r.nx = q[15:0];
				1: r.ny = q[15:0];
				default: r.nz = q[15:0];
			endcase
		end
		return r;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	// Drives one word and holds it until it is taken. Valid stays high into
	// the next word unless an idle cycle follows.
	task automatic send(row_t w);
		normal_t e;
		while (!quiet_now() && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= w.op;
		vertex_index <= w.idx;
		coord_x <= w.x;
		coord_y <= w.y;
		coord_z <= w.z;
		corner_a <= w.a;
		corner_b <= w.b;
		corner_c <= w.c;
		last_face <= w.last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (w.op == tfn_pkg::OP_WRITE) begin
			vstore[w.idx][0] = w.x;
			vstore[w.idx][1] = w.y;
			vstore[w.idx][2] = w.z;
			if (!written[w.idx])
				written_list.insert(written_list.size(), w.idx);
			written[w.idx] = 1'b1;
			n_writes++;
		end else begin
			e = face_normal(w.a, w.b, w.c, w.last);
			if (w.typed) begin
				e.nx = w.nx;
				e.ny = w.ny;
				e.nz = w.nz;
				e.deg = w.deg;
			end
			pending_normals.insert(pending_normals.size(), e);
			n_faces++;
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		out_stall <= !quiet_now() && $urandom_range(99) < 22;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_normals.size() == 0) begin
				report("normal words pending", 1, 0);
			end else begin
				normal_t e;
				e = pending_normals.pop_front();
				if (normal_x !== e.nx) report("normal_x", normal_x, e.nx);
				if (normal_y !== e.ny) report("normal_y", normal_y, e.ny);
				if (normal_z !== e.nz) report("normal_z", normal_z, e.nz);
				if (degenerate !== e.deg) report("degenerate", degenerate, e.deg);
				if (last_normal !== e.last) report("last_normal", last_normal, e.last);
				n_checked++;
				if (e.deg)
					n_degenerate++;
			end
		end
	end

	row_t directed [] = '{
		'{tfn_pkg::OP_WRITE, 10'd0, 16'sd0, 16'sd0, 16'sd0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{tfn_pkg::OP_WRITE, 10'd1, 16'sd256, 16'sd0, 16'sd0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{tfn_pkg::OP_WRITE, 10'd2, 16'sd0, 16'sd256, 16'sd0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{tfn_pkg::OP_WRITE, 10'd1023, 16'sd32767, 16'sd32767, 16'sd32767,
			10'h3FF, 10'h3FF, 10'h3FF, 1, 0, 0, 0, 0, 0},
		'{tfn_pkg::OP_WRITE, 10'd512, -16'sd32768, -16'sd32768, -16'sd32768,
			0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{tfn_pkg::OP_WRITE, 10'd3, -16'sd32768, 16'sd32767, 16'sd0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{tfn_pkg::OP_WRITE, 10'd4, 16'sd5, -16'sd7, 16'sd32767, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{tfn_pkg::OP_FACE, 10'h3FF, -16'sd1, -16'sd1, -16'sd1, 10'd0, 10'd0, 10'd0, 0,
			1, 16'sd0, 16'sd0, 16'sd0, 1'b1},
		'{tfn_pkg::OP_FACE, 0, 0, 0, 0, 10'd0, 10'd1, 10'd2, 1,
			1, 16'sd0, 16'sd0, 16'sd16384, 1'b0},
		'{tfn_pkg::OP_FACE, 0, 0, 0, 0, 10'd0, 10'd2, 10'd1, 0,
			1, 16'sd0, 16'sd0, -16'sd16384, 1'b0},
		'{tfn_pkg::OP_FACE, 0, 0, 0, 0, 10'd0, 10'd1023, 10'd512, 1,
			1, 16'sd0, 16'sd0, 16'sd0, 1'b1},
		'{tfn_pkg::OP_FACE, 0, 0, 0, 0, 10'd1, 10'd1, 10'd2, 0,
			1, 16'sd0, 16'sd0, 16'sd0, 1'b1},
		'{tfn_pkg::OP_FACE, 0, 0, 0, 0, 10'd512, 10'd1023, 10'd3, 0, 0, 0, 0, 0, 0},
		'{tfn_pkg::OP_FACE, 0, 0, 0, 0, 10'd3, 10'd4, 10'd1023, 1, 0, 0, 0, 0, 0},
		'{tfn_pkg::OP_FACE, 0, 0, 0, 0, 10'd1023, 10'd3, 10'd512, 0, 0, 0, 0, 0, 0},
		'{tfn_pkg::OP_FACE, 0, 0, 0, 0, 10'd4, 10'd0, 10'd1, 1, 0, 0, 0, 0, 0}
	};

	initial begin
		row_t w;
		int waited;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send(directed[i]);
		for (int n = 0; n < 1500; n++) begin
			w.typed = 0;
			w.idx = 10'($urandom);
			w.x = 16'($urandom);
			w.y = 16'($urandom);
			w.z = 16'($urandom);
			w.a = 10'($urandom);
			w.b = 10'($urandom);
			w.c = 10'($urandom);
			w.last = 1'($urandom);
			if ($urandom_range(99) < 30) begin
				w.op = tfn_pkg::OP_WRITE;
				// Small coordinates now and then give short, rounding-sensitive normals.
				if ($urandom_range(3) == 0) begin
					w.x = 16'($signed($urandom_range(8)) - 4);
					w.y = 16'($signed($urandom_range(8)) - 4);
					w.z = 16'($signed($urandom_range(8)) - 4);
				end
			end else begin
				w.op = tfn_pkg::OP_FACE;
				w.a = written_list[$urandom_range(written_list.size() - 1)];
				w.b = written_list[$urandom_range(written_list.size() - 1)];
				w.c = written_list[$urandom_range(written_list.size() - 1)];
				if ($urandom_range(9) == 0)
					w.c = w.a;
			end
			send(w);
		end
		in_valid <= 1'b0;
		waited = 0;
		while (pending_normals.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (200) @(posedge clk);
		$display("covered %0d vertex writes and %0d faces, %0d normals checked",
			n_writes, n_faces, n_checked);
		$display("%0d degenerate faces, %0d normals still pending",
			n_degenerate, pending_normals.size());
		if (pending_normals.size() != 0)
			errors++;
		if (errors == 0)
			$display("triangle_face_normal_core_tb: done, clean");
		else
			$display("triangle_face_normal_core_tb: done, errors");
		$finish;
	end

	initial begin
		#20000000;
		$display("timeout");
		$display("triangle_face_normal_core_tb: done, errors");
		$finish;
	end

endmodule
